@@ sv/hxy_pkg.sv @@
// Shared types, constants and curve tables for the Hilbert xy-to-index block.
`default_nettype none

package hxy_pkg;

    localparam int COORD_W          = 16;
    localparam int COORD_IDX_W      = 4;
    localparam int INDEX_W          = 32;
    localparam int LVL_W            = 5;
    localparam int LEVELS_PER_STAGE = 4;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QUEUE_PTR_W      = 2;
    localparam int QUEUE_CNT_W      = 3;

    localparam logic [LVL_W-1:0] LEVELS_RESET = 5'd16;

    typedef logic [1:0] curve_state_t;
    typedef logic [1:0] quadrant_t;

    typedef struct packed {
        logic [COORD_W-1:0] x_coord;
        logic [COORD_W-1:0] y_coord;
        logic [LVL_W-1:0]   levels;
    } point_t;

    typedef struct packed {
        point_t             pt;
        curve_state_t       st;
        logic [INDEX_W-1:0] acc;
    } walk_t;

    // [state][quadrant]
    localparam curve_state_t NEXT_STATE_TBL [4][4] = '{
        '{2'd0, 2'd0, 2'd1, 2'd2},
        '{2'd3, 2'd1, 2'd0, 2'd1},
        '{2'd2, 2'd3, 2'd2, 2'd0},
        '{2'd1, 2'd2, 2'd3, 2'd3}
    };

    localparam logic [1:0] DIGIT_TBL [4][4] = '{
        '{2'd1, 2'd2, 2'd0, 2'd3},
        '{2'd3, 2'd2, 2'd0, 2'd1},
        '{2'd1, 2'd0, 2'd2, 2'd3},
        '{2'd3, 2'd0, 2'd2, 2'd1}
    };

    function automatic curve_state_t hxy_next_state(input curve_state_t st, input quadrant_t q);
        return NEXT_STATE_TBL[st][q];
    endfunction

    function automatic logic [1:0] hxy_digit(input curve_state_t st, input quadrant_t q);
        return DIGIT_TBL[st][q];
    endfunction

endpackage

`default_nettype wire

@@ sv/hxy_front.sv @@
// Front end: level count register, input transfer and level clamping.
`default_nettype none

module hxy_front #(
    parameter int MAX_LEVELS = 16
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [hxy_pkg::LVL_W-1:0]   cfg_levels_in_use,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  [hxy_pkg::COORD_W-1:0] s_x_coord,
    input  wire  [hxy_pkg::COORD_W-1:0] s_y_coord,
    output logic                        out_valid,
    input  wire                         out_ready,
    output hxy_pkg::point_t             out_item
);
    import hxy_pkg::*;

    localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_LEVELS);

    logic [LVL_W-1:0] levels_reg;
    logic [LVL_W-1:0] levels_eff;
    logic             valid_reg;
    point_t           item_reg;
    point_t           item_next;

    assign cfg_ready  = 1'b1;
    assign s_ready    = !valid_reg || out_ready;
    assign levels_eff = (levels_reg > MAX_LVL) ? MAX_LVL : levels_reg;

    always_comb begin
        item_next.x_coord = s_x_coord;
        item_next.y_coord = s_y_coord;
        item_next.levels  = levels_eff;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg <= LEVELS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            levels_reg <= cfg_levels_in_use;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

@@ sv/hxy_queue.sv @@
// Small FIFO between the front end and the level pipeline.
`default_nettype none

module hxy_queue (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              push_valid,
    output logic             push_ready,
    input  hxy_pkg::point_t  push_item,
    output logic             pop_valid,
    input  wire              pop_ready,
    output hxy_pkg::point_t  pop_item
);
    import hxy_pkg::*;

    point_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic                   push;
    logic                   pop;

    assign push_ready = count_reg < QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

endmodule

`default_nettype wire

@@ sv/hxy_back.sv @@
// Level pipeline: four curve levels per stage, most significant level first.
`default_nettype none

module hxy_back #(
    parameter int MAX_LEVELS = 16
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         in_valid,
    output logic                        in_ready,
    input  hxy_pkg::point_t             in_item,
    output logic                        out_valid,
    input  wire                         out_ready,
    output logic [hxy_pkg::INDEX_W-1:0] out_index
);
    import hxy_pkg::*;

    localparam int NUM_STAGES = (MAX_LEVELS + LEVELS_PER_STAGE - 1) / LEVELS_PER_STAGE;
    localparam int LAST       = NUM_STAGES - 1;

    walk_t stage_in    [NUM_STAGES];
    walk_t walk_next   [NUM_STAGES];
    walk_t walk_reg    [NUM_STAGES];
    logic  valid_in    [NUM_STAGES];
    logic  vld_reg     [NUM_STAGES];
    logic  stage_ready [NUM_STAGES];
    logic  down_ready  [NUM_STAGES];

    genvar s;
    generate
        for (s = 0; s < NUM_STAGES; s++) begin : g_stage
            if (s > 0) begin : g_link
                assign stage_in[s] = walk_reg[s-1];
                assign valid_in[s] = vld_reg[s-1];
            end else begin : g_head
                assign stage_in[s] = '{pt: in_item, st: '0, acc: '0};
                assign valid_in[s] = in_valid;
            end
            if (s == LAST) begin : g_tail
                assign down_ready[s] = out_ready;
            end else begin : g_mid
                assign down_ready[s] = stage_ready[s+1];
            end

            assign stage_ready[s] = !vld_reg[s] || down_ready[s];

            always_comb begin
                walk_t     w;
                int        pos;
                quadrant_t q;
                w   = stage_in[s];
                pos = 0;
                q   = '0;
                for (int j = 0; j < LEVELS_PER_STAGE; j++) begin
                    pos = MAX_LEVELS - 1 - s * LEVELS_PER_STAGE - j;
                    if (pos >= 0 && pos < int'(w.pt.levels)) begin
                        q = '0;
                        if (pos < COORD_W) begin
                            q = {w.pt.y_coord[pos[COORD_IDX_W-1:0]],
                                 w.pt.x_coord[pos[COORD_IDX_W-1:0]]};
                        end
                        w.acc = {w.acc[INDEX_W-3:0], hxy_digit(w.st, q)};
                        w.st  = hxy_next_state(w.st, q);
                    end
                end
                walk_next[s] = w;
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[s] <= 1'b0;
                end else if (stage_ready[s]) begin
                    vld_reg[s] <= valid_in[s];
                end
            end

            always_ff @(posedge aclk) begin
                if (stage_ready[s] && valid_in[s]) begin
                    walk_reg[s] <= walk_next[s];
                end
            end
        end
    endgenerate

    assign in_ready  = stage_ready[0];
    assign out_valid = vld_reg[LAST];
    assign out_index = walk_reg[LAST].acc;

    a_zero_levels: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && walk_reg[LAST].pt.levels == '0 |-> out_index == '0)
        else $error("index not zero with no levels");

    a_index_width: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && walk_reg[LAST].pt.levels < 5'd16
        |-> (out_index >> {walk_reg[LAST].pt.levels, 1'b0}) == '0)
        else $error("index wider than two bits per level");

endmodule

`default_nettype wire

@@ sv/hilbert_xy_to_index.sv @@
// Top level: grid point to Hilbert curve position.
//
//  port group          dir  handshake            payload
//  cfg_*               in   cfg_valid/cfg_ready  cfg_levels_in_use[4:0]
//  s_*                 in   s_valid/s_ready      s_x_coord[15:0], s_y_coord[15:0]
//  m_*                 out  m_valid/m_ready      m_curve_index[31:0]
//
// One point per cycle sustained while m_ready is high; the path is the front register,
// the queue, then one pipeline stage per four curve levels.
// Reset sets levels_in_use to 16 and empties the queue and pipeline.
// With m_ready low the pipeline and the four-entry queue fill, then s_ready drops.
`default_nettype none

module hilbert_xy_to_index #(
    parameter int MAX_LEVELS = 16
) (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         cfg_valid,
    output logic                        cfg_ready,
    input  wire  [hxy_pkg::LVL_W-1:0]   cfg_levels_in_use,
    input  wire                         s_valid,
    output logic                        s_ready,
    input  wire  [hxy_pkg::COORD_W-1:0] s_x_coord,
    input  wire  [hxy_pkg::COORD_W-1:0] s_y_coord,
    output logic                        m_valid,
    input  wire                         m_ready,
    output logic [hxy_pkg::INDEX_W-1:0] m_curve_index
);
    import hxy_pkg::*;

    logic   fq_valid;
    logic   fq_ready;
    point_t fq_item;
    logic   qb_valid;
    logic   qb_ready;
    point_t qb_item;

    hxy_front #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_levels_in_use (cfg_levels_in_use),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_x_coord         (s_x_coord),
        .s_y_coord         (s_y_coord),
        .out_valid         (fq_valid),
        .out_ready         (fq_ready),
        .out_item          (fq_item)
    );

    hxy_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    hxy_back #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (qb_valid),
        .in_ready  (qb_ready),
        .in_item   (qb_item),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_index (m_curve_index)
    );

endmodule

`default_nettype wire
